@@ design/att_pkg.sv @@
// Shared types and constants for the alarm timer table.
// Holds the slot record layout, the operation codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

	// Handle counter reset value and the step between handles.
	localparam logic [31:0] HANDLE_BASE_RESET = 32'h3FFE_8000;
	localparam logic [31:0] HANDLE_STEP       = 32'd4;

	// Request operation codes. Code 7 has no meaning and is answered with an error.
	typedef enum logic [2:0] {
		OP_CREATE     = 3'd0,
		OP_START_ONCE = 3'd1,
		OP_START_PER  = 3'd2,
		OP_STOP       = 3'd3,
		OP_DELETE     = 3'd4,
		OP_QUERY      = 3'd5,
		OP_TICK       = 3'd6
	} opcode_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_HIT  = 4'b1000
	} state_t;

	// One slot of the timer table, stored as a single memory word.
	typedef struct packed {
		logic [31:0] handle;
		logic [31:0] callback;
		logic [31:0] argument;
		logic        active;
		logic        periodic;
		logic [63:0] period;
		logic [63:0] alarm;
	} slot_rec_t;

endpackage

`default_nettype wire

@@ design/att_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the timer slot table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module att_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/alarm_timer_table.sv @@
// Top level of the alarm timer table: request sequencer, slot scan and result register.
// Depends on att_pkg and att_ram.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Handshake               | Payload
//  ---------+-------------------------+---------------------------------------------
//  request  | in_valid / in_ready     | operation, handle, callback_address,
//           |                         | callback_argument, duration_us, now_us
//  result   | out_valid / out_ready   | status, new_handle, is_running, fired,
//           |                         | fired_callback, fired_argument, last
//  config   | cfg_wr_en               | cfg_wr_data (handle base, reloads the counter)
//
// Create and undefined operations are answered from the execute state, without a scan.
// Start, stop, delete and query walk the slot table through the single RAM read port,
// one slot per cycle until a matching slot ends the walk. Tick walks all used slots the
// same way and, on each expired timer, does the write-back and then restarts the read.
// Reset clears only control state; no clearing pass over the RAM is needed. A stalled
// result beat holds the sequencer at its next result load; a new request is taken once
// the sequencer is back in idle.

module alarm_timer_table #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] handle,
	input  wire logic [31:0] callback_address,
	input  wire logic [31:0] callback_argument,
	input  wire logic [63:0] duration_us,
	input  wire logic [63:0] now_us,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [31:0]      new_handle,
	output logic             is_running,
	output logic             fired,
	output logic [31:0]      fired_callback,
	output logic [31:0]      fired_argument,
	output logic             last
);

	import att_pkg::*;

	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	// Control state.
	state_t         state_q;
	logic [CW-1:0]  used_q;
	logic [CW-1:0]  idx_q;
	logic           chk_vld_q;
	logic [AW-1:0]  chk_idx_q;
	logic [31:0]    next_handle_q;
	logic           pend_vld_q;
	logic           out_valid_q;

	// Latched request and pending fire beat.
	opcode_t        op_q;
	logic [31:0]    handle_q;
	logic [31:0]    cb_q;
	logic [31:0]    arg_q;
	logic [63:0]    dur_q;
	logic [63:0]    now_q;
	logic [31:0]    pend_cb_q;
	logic [31:0]    pend_arg_q;

	// Result register.
	logic           status_q;
	logic [31:0]    new_handle_q;
	logic           is_running_q;
	logic           fired_q;
	logic [31:0]    fired_cb_q;
	logic [31:0]    fired_arg_q;
	logic           last_q;

	// RAM signals.
	slot_rec_t      rd_rec;
	slot_rec_t      wr_rec;
	logic           rd_en;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;

	// Combinational helpers.
	logic           is_tick;
	logic           is_start;
	logic           full;
	logic           hit;
	logic           scan_done;
	logic           out_free;
	logic           tick_go;
	logic [63:0]    add_a;
	logic [63:0]    add_b;
	logic [63:0]    add_sum;

	// Result load.
	logic           ld_en;
	logic           ld_status;
	logic [31:0]    ld_new_handle;
	logic           ld_is_running;
	logic           ld_fired;
	logic [31:0]    ld_cb;
	logic [31:0]    ld_arg;
	logic           ld_last;

	att_ram #(
		.WIDTH ($bits(slot_rec_t)),
		.DEPTH (TIMER_SLOTS)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_rec)
	);

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign new_handle     = new_handle_q;
	assign is_running     = is_running_q;
	assign fired          = fired_q;
	assign fired_callback = fired_cb_q;
	assign fired_argument = fired_arg_q;
	assign last           = last_q;

	// Decode and scan conditions.
	assign is_tick   = (op_q == OP_TICK);
	assign is_start  = (op_q == OP_START_ONCE) || (op_q == OP_START_PER);
	assign full      = (used_q >= CW'(TIMER_SLOTS));
	assign out_free  = !out_valid_q || out_ready;
	assign tick_go   = !pend_vld_q || out_free;
	assign hit       = is_tick ? (rd_rec.active && (now_q >= rd_rec.alarm))
	                           : (rd_rec.handle == handle_q);
	assign scan_done = !chk_vld_q && (idx_q == used_q);
	assign rd_en     = (state_q == ST_SCAN) && (idx_q != used_q) && !(chk_vld_q && hit);

	// Shared 64-bit adder: start computes now + duration, tick advances by one period.
	assign add_a   = is_tick ? rd_rec.alarm : now_q;
	assign add_b   = is_tick ? rd_rec.period : dur_q;
	assign add_sum = add_a + add_b;

	// Slot write-back for create and for a matched slot.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_idx_q;
		wr_rec  = rd_rec;
		unique case (state_q)
			ST_EXEC: begin
				if (op_q == OP_CREATE && out_free && !full) begin
					wr_en           = 1'b1;
					wr_addr         = used_q[AW-1:0];
					wr_rec.handle   = next_handle_q;
					wr_rec.callback = cb_q;
					wr_rec.argument = arg_q;
					wr_rec.active   = 1'b0;
					wr_rec.periodic = 1'b0;
					wr_rec.period   = '0;
					wr_rec.alarm    = '0;
				end
			end
			ST_HIT: begin
				unique case (op_q)
					OP_START_ONCE, OP_START_PER: begin
						wr_en           = out_free;
						wr_rec.active   = 1'b1;
						wr_rec.periodic = (op_q == OP_START_PER);
						wr_rec.period   = (op_q == OP_START_PER) ? dur_q : '0;
						wr_rec.alarm    = add_sum;
					end
					OP_STOP: begin
						wr_en         = out_free;
						wr_rec.active = 1'b0;
					end
					OP_DELETE: begin
						wr_en         = out_free;
						wr_rec.active = 1'b0;
						wr_rec.handle = '0;
					end
					OP_TICK: begin
						wr_en = tick_go;
						if (rd_rec.periodic) begin
							wr_rec.alarm = add_sum;
						end else begin
							wr_rec.active = 1'b0;
						end
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Result beat selection.
	always_comb begin
		ld_en         = 1'b0;
		ld_status     = 1'b0;
		ld_new_handle = '0;
		ld_is_running = 1'b0;
		ld_fired      = 1'b0;
		ld_cb         = '0;
		ld_arg        = '0;
		ld_last       = 1'b1;
		unique case (state_q)
			ST_EXEC: begin
				ld_en = out_free;
				if (op_q == OP_CREATE) begin
					ld_status     = full;
					ld_new_handle = full ? '0 : next_handle_q;
				end else begin
					ld_status = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					ld_en = out_free;
					if (is_tick) begin
						ld_fired = pend_vld_q;
						ld_cb    = pend_vld_q ? pend_cb_q : '0;
						ld_arg   = pend_vld_q ? pend_arg_q : '0;
					end else begin
						ld_status = is_start;
					end
				end
			end
			ST_HIT: begin
				if (is_tick) begin
					// A newer expiry proves the held one is not the final beat.
					ld_en    = pend_vld_q && out_free;
					ld_fired = 1'b1;
					ld_cb    = pend_cb_q;
					ld_arg   = pend_arg_q;
					ld_last  = 1'b0;
				end else begin
					ld_en         = out_free;
					ld_is_running = (op_q == OP_QUERY) && rd_rec.active;
				end
			end
			default: begin
				ld_en = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			idx_q         <= '0;
			chk_vld_q     <= 1'b0;
			next_handle_q <= HANDLE_BASE_RESET;
			pend_vld_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ld_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q      <= '0;
						chk_vld_q  <= 1'b0;
						pend_vld_q <= 1'b0;
						if (operation == OP_CREATE || operation > OP_TICK) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (op_q == OP_CREATE && !full) begin
							used_q        <= used_q + CW'(1);
							next_handle_q <= next_handle_q + HANDLE_STEP;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					chk_vld_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (chk_vld_q && hit) begin
						state_q <= ST_HIT;
					end else if (scan_done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_HIT: begin
					if (is_tick) begin
						if (tick_go) begin
							pend_vld_q <= 1'b1;
							state_q    <= ST_SCAN;
						end
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// The handle base is to be written only while idle; the block does not enforce this. A write restarts the counter.
			if (cfg_wr_en) begin
				next_handle_q <= cfg_wr_data;
			end
		end
	end

	// Request latch, read address tracking, pending beat and result payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= opcode_t'(operation);
			handle_q <= handle;
			cb_q     <= callback_address;
			arg_q    <= callback_argument;
			dur_q    <= duration_us;
			now_q    <= now_us;
		end
		if (rd_en) begin
			chk_idx_q <= idx_q[AW-1:0];
		end
		if (state_q == ST_HIT && is_tick && tick_go) begin
			pend_cb_q  <= rd_rec.callback;
			pend_arg_q <= rd_rec.argument;
		end
		if (ld_en) begin
			status_q     <= ld_status;
			new_handle_q <= ld_new_handle;
			is_running_q <= ld_is_running;
			fired_q      <= ld_fired;
			fired_cb_q   <= ld_cb;
			fired_arg_q  <= ld_arg;
			last_q       <= ld_last;
		end
	end

endmodule

`default_nettype wire
